// ===== hw/rtl/sud_pkg.sv =====
// shared types and constants of the strict utf-8 decoder
package sud_pkg;

	localparam int OFFSET_BITS = 32;
	localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

	localparam int CODE_BITS = 21;
	localparam int START_BITS = 32;
	localparam int OUT_DATA_BITS = 56;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BAD2     = 3'd1,
		ST_BAD3     = 3'd2,
		ST_OVER3    = 3'd3,
		ST_BAD4     = 3'd4,
		ST_OVER4    = 3'd5,
		ST_BAD_LEAD = 3'd6
	} status_t;

	typedef struct packed {
		logic [1:0]             bytes_remaining;
		logic [2:0]             sequence_length;
		logic [CODE_BITS-1:0]   partial_code;
		logic                   range_fault_pending;
		logic [OFFSET_BITS-1:0] sequence_start;
		logic [OFFSET_BITS-1:0] byte_position;
		logic                   discarding;
	} dec_state_t;

	typedef struct packed {
		logic                  valid;
		logic [CODE_BITS-1:0]  code_point;
		status_t               status;
		logic [START_BITS-1:0] start_offset;
		logic                  string_done;
	} dec_result_t;

endpackage

// ===== hw/rtl/strict_utf8_decoder.sv =====
// top level of the strict utf-8 decoder: input register, decode state, result register
//
// Takes one byte per item and can accept a byte in every clock cycle. A byte
// is held in an input register, then goes through the decode logic, which
// updates the sequence state and loads the result register, from which a
// result item is offered for the byte that completes or breaks a scalar.
// Continuation bytes that do not finish a scalar, and bytes dropped after an
// error up to the end of the string, give no result item. A stall on the
// result side holds the input register and then the input side. The start
// offset counts bytes from the start of the string and saturates.
module strict_utf8_decoder import sud_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [7:0]               s_tdata,   // [7:0] data_byte
	input  logic                     s_tlast,   // end_of_string
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [OUT_DATA_BITS-1:0] m_tdata,   // [20:0] code_point, [52:21] start_offset
	output logic [2:0]               m_tuser,   // [2:0] status
	output logic                     m_tlast    // string_done
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eos_s1;
	logic        adv_s1;
	dec_state_t  state_q;
	dec_state_t  state_next;
	dec_result_t res;
	logic        out_valid_q;
	logic [CODE_BITS-1:0]  code_q;
	status_t               status_q;
	logic [START_BITS-1:0] start_q;
	logic                  done_q;

	assign adv_s1   = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			eos_s1  <= s_tlast;
		end
	end

	sud_step u_step (
		.cur       (state_q),
		.data_byte (byte_s1),
		.eos       (eos_s1),
		.nxt       (state_next),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (valid_s1 && adv_s1) begin
				state_q <= state_next;
			end
			if (adv_s1) begin
				out_valid_q <= valid_s1 && res.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1 && res.valid) begin
			code_q   <= res.code_point;
			status_q <= res.status;
			start_q  <= res.start_offset;
			done_q   <= res.string_done;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DATA_BITS'({start_q, code_q});
	assign m_tuser  = status_q;
	assign m_tlast  = done_q;

endmodule

// ===== hw/rtl/sud_step.sv =====
// per-byte decode logic: next state and the result of one byte
module sud_step import sud_pkg::*; (
	input  dec_state_t  cur,
	input  logic [7:0]  data_byte,
	input  logic        eos,
	output dec_state_t  nxt,
	output dec_result_t res
);

	logic                   error;
	status_t                err_status;
	status_t                len_status;
	logic                   second;
	logic [1:0]             rem_dec;
	logic [CODE_BITS-1:0]   shifted;
	logic [63:0]            start_ext;
	logic [OFFSET_BITS-1:0] res_start;

	always_comb begin
		case (cur.sequence_length)
			3'd2:    len_status = ST_BAD2;
			3'd3:    len_status = ST_BAD3;
			default: len_status = ST_BAD4;
		endcase
	end

	assign second  = (({1'b0, cur.bytes_remaining} + 3'd1) == cur.sequence_length);
	assign rem_dec = cur.bytes_remaining - 2'd1;
	assign shifted = {cur.partial_code[CODE_BITS-7:0], data_byte[5:0]};

	always_comb begin
		nxt        = cur;
		res        = '0;
		res.status = ST_OK;
		error      = 1'b0;
		err_status = ST_OK;
		res_start  = cur.sequence_start;

		nxt.byte_position = (cur.byte_position == OFFSET_MAX) ? OFFSET_MAX
			: cur.byte_position + OFFSET_BITS'(1);

		if (cur.discarding) begin
			// byte dropped
		end else if (cur.bytes_remaining == 2'd0) begin
			nxt.sequence_start = cur.byte_position;
			res_start          = cur.byte_position;
			if (data_byte <= 8'h7f) begin
				res.valid       = 1'b1;
				res.code_point  = CODE_BITS'(data_byte);
				res.string_done = eos;
			end else if (data_byte inside {[8'hc2:8'hdf]}) begin
				nxt.sequence_length = 3'd2;
				nxt.bytes_remaining = 2'd1;
				nxt.partial_code    = CODE_BITS'(data_byte[4:0]);
				if (eos) begin
					error = 1'b1; err_status = ST_BAD2;
				end
			end else if (data_byte inside {[8'he0:8'hef]}) begin
				nxt.sequence_length = 3'd3;
				nxt.bytes_remaining = 2'd2;
				nxt.partial_code    = CODE_BITS'(data_byte[3:0]);
				if (eos) begin
					error = 1'b1; err_status = ST_BAD3;
				end
			end else if (data_byte inside {[8'hf0:8'hf4]}) begin
				nxt.sequence_length = 3'd4;
				nxt.bytes_remaining = 2'd3;
				nxt.partial_code    = CODE_BITS'(data_byte[2:0]);
				if (eos) begin
					error = 1'b1; err_status = ST_BAD4;
				end
			end else begin
				error = 1'b1; err_status = ST_BAD_LEAD;
			end
		end else begin
			if (data_byte < 8'h80 || data_byte > 8'hbf) begin
				error = 1'b1; err_status = len_status;
			end else begin
				// overlong, surrogate and range faults show on the second byte
				if (second && cur.sequence_length == 3'd3) begin
					if ((cur.partial_code == CODE_BITS'(0) && data_byte < 8'ha0) ||
					    (cur.partial_code == CODE_BITS'(13) && data_byte > 8'h9f))
						nxt.range_fault_pending = 1'b1;
				end else if (second && cur.sequence_length == 3'd4) begin
					if ((cur.partial_code == CODE_BITS'(0) && data_byte < 8'h90) ||
					    (cur.partial_code == CODE_BITS'(4) && data_byte > 8'h8f))
						nxt.range_fault_pending = 1'b1;
				end
				nxt.partial_code    = shifted;
				nxt.bytes_remaining = rem_dec;
				if (rem_dec == 2'd0) begin
					if (nxt.range_fault_pending) begin
						error      = 1'b1;
						err_status = (cur.sequence_length == 3'd3) ? ST_OVER3 : ST_OVER4;
					end else begin
						res.valid               = 1'b1;
						res.code_point          = shifted;
						res.string_done         = eos;
						nxt.bytes_remaining     = 2'd0;
						nxt.sequence_length     = 3'd0;
						nxt.partial_code        = '0;
						nxt.range_fault_pending = 1'b0;
					end
				end else if (eos) begin
					error = 1'b1; err_status = len_status;
				end
			end
		end

		if (error) begin
			res.valid               = 1'b1;
			res.code_point          = '0;
			res.status              = err_status;
			res.string_done         = 1'b1;
			nxt.bytes_remaining     = 2'd0;
			nxt.sequence_length     = 3'd0;
			nxt.partial_code        = '0;
			nxt.range_fault_pending = 1'b0;
			nxt.discarding          = 1'b1;
		end

		if (eos) begin
			nxt.bytes_remaining     = 2'd0;
			nxt.sequence_length     = 3'd0;
			nxt.partial_code        = '0;
			nxt.range_fault_pending = 1'b0;
			nxt.discarding          = 1'b0;
			nxt.byte_position       = '0;
		end

		start_ext        = 64'(res_start);
		res.start_offset = start_ext[START_BITS-1:0];
	end

endmodule

// ===== hw/rtl/sud_checker.sv =====
// port-level assertions of the strict utf-8 decoder and their bind
module sud_checker import sud_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     m_tvalid,
	input logic                     m_tready,
	input logic [OUT_DATA_BITS-1:0] m_tdata,
	input logic [2:0]               m_tuser,
	input logic                     m_tlast
);

	// a stalled result item holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result item changed while stalled");

	// an error ends the string and carries no code point
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_OK |-> m_tlast && m_tdata[CODE_BITS-1:0] == '0)
		else $error("error item without string end or with code point");

	// good scalars are never surrogates or above the unicode range
	a_scalar: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_OK |->
			m_tdata[CODE_BITS-1:0] <= 21'h10ffff &&
			!(m_tdata[CODE_BITS-1:0] >= 21'h00d800 && m_tdata[CODE_BITS-1:0] <= 21'h00dfff))
		else $error("invalid scalar value on a good item");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser != 3'd7)
		else $error("unknown status code");

endmodule

bind strict_utf8_decoder sud_checker u_sud_checker (.*);

// ===== test/testbench.sv =====
// testbench for the strict utf-8 decoder: byte strings checked against a behavioral decoder
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sud_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		logic [CODE_BITS-1:0]  code;
		status_t               status;
		logic [START_BITS-1:0] start;
		logic                  done;
	} scalar_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     s_tvalid = 1'b0;
	logic                     s_tready;
	logic [7:0]               s_tdata = 8'h00;
	logic                     s_tlast = 1'b0;
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	logic [OUT_DATA_BITS-1:0] m_tdata;
	logic [2:0]               m_tuser;
	logic                     m_tlast;

	scalar_t    pending_scalars[$];
	logic [7:0] text_q[$];
	logic       stall_en = 1'b1;
	int         mismatch_count = 0;
	int         sent_bytes = 0;
	int         cycle_count = 0;

	// decoder state of the behavioral model
	logic [1:0]             seq_left = '0;
	logic [2:0]             seq_len = '0;
	logic [CODE_BITS-1:0]   code_acc = '0;
	logic                   range_bad = 1'b0;
	logic [OFFSET_BITS-1:0] lead_pos = '0;
	logic [OFFSET_BITS-1:0] next_pos = '0;
	logic                   skipping = 1'b0;

	strict_utf8_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic status_t length_fault(input logic [2:0] len);
		if (len == 3'd2)
			return ST_BAD2;
		if (len == 3'd3)
			return ST_BAD3;
		return ST_BAD4;
	endfunction

	function automatic void clear_seq();
		seq_left = '0;
		seq_len = '0;
		code_acc = '0;
		range_bad = 1'b0;
	endfunction

	function automatic void push_scalar(input logic [CODE_BITS-1:0] code, input status_t status,
			input logic [OFFSET_BITS-1:0] start, input logic done);
		scalar_t r;
		r.code = code;
		r.status = status;
		r.start = start[START_BITS-1:0];
		r.done = done;
		pending_scalars.push_back(r);
	endfunction

	// advances the model by one accepted byte and queues the scalar it yields, if any
	function automatic void decode_byte(input logic [7:0] b, input logic last);
		logic [OFFSET_BITS-1:0] pos;
		logic                   fail;
		status_t                fail_status;
		logic                   second;
		pos = next_pos;
		fail = 1'b0;
		fail_status = ST_OK;
		if (next_pos != OFFSET_MAX)
			next_pos = next_pos + OFFSET_BITS'(1);
		if (skipping) begin
			// byte dropped after an error
		end else if (seq_left == 2'd0) begin
			lead_pos = pos;
			if (b <= 8'h7f) begin
				push_scalar(CODE_BITS'(b), ST_OK, pos, last);
			end else if (b >= 8'hc2 && b <= 8'hdf) begin
				seq_len = 3'd2;
				seq_left = 2'd1;
				code_acc = CODE_BITS'(b[4:0]);
			end else if (b >= 8'he0 && b <= 8'hef) begin
				seq_len = 3'd3;
				seq_left = 2'd2;
				code_acc = CODE_BITS'(b[3:0]);
			end else if (b >= 8'hf0 && b <= 8'hf4) begin
				seq_len = 3'd4;
				seq_left = 2'd3;
				code_acc = CODE_BITS'(b[2:0]);
			end else begin
				fail = 1'b1;
				fail_status = ST_BAD_LEAD;
			end
			if (!fail && seq_left != 2'd0 && last) begin
				fail = 1'b1;
				fail_status = length_fault(seq_len);
			end
		end else if (b < 8'h80 || b > 8'hbf) begin
			fail = 1'b1;
			fail_status = length_fault(seq_len);
		end else begin
			second = ({1'b0, seq_left} + 3'd1 == seq_len);
			// overlong, surrogate and range faults show in the second byte
			if (second && seq_len == 3'd3 &&
					((code_acc == CODE_BITS'(0) && b < 8'ha0) ||
					 (code_acc == CODE_BITS'(13) && b > 8'h9f)))
				range_bad = 1'b1;
			if (second && seq_len == 3'd4 &&
					((code_acc == CODE_BITS'(0) && b < 8'h90) ||
					 (code_acc == CODE_BITS'(4) && b > 8'h8f)))
				range_bad = 1'b1;
			code_acc = {code_acc[CODE_BITS-7:0], b[5:0]};
			seq_left = seq_left - 2'd1;
			if (seq_left == 2'd0) begin
				if (range_bad) begin
					fail = 1'b1;
					fail_status = (seq_len == 3'd3) ? ST_OVER3 : ST_OVER4;
				end else begin
					push_scalar(code_acc, ST_OK, lead_pos, last);
					clear_seq();
				end
			end else if (last) begin
				fail = 1'b1;
				fail_status = length_fault(seq_len);
			end
		end
		if (fail) begin
			push_scalar('0, fail_status, lead_pos, 1'b1);
			clear_seq();
			skipping = 1'b1;
		end
		if (last) begin
			clear_seq();
			skipping = 1'b0;
			next_pos = '0;
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last);
		while (stall_en && $urandom_range(99) < 30) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		decode_byte(b, last);
		sent_bytes++;
	endtask

	task automatic send_string();
		for (int i = 0; i < text_q.size(); i++)
			send_byte(text_q[i], i == text_q.size() - 1);
	endtask

	function automatic logic [7:0] rand_byte(input logic [7:0] lo, input logic [7:0] hi);
		return 8'($urandom_range(32'(hi), 32'(lo)));
	endfunction

	function automatic logic [20:0] random_scalar();
		logic [20:0] cp;
		case ($urandom_range(3))
			0: cp = 21'($urandom_range(32'h7f, 0));
			1: cp = 21'($urandom_range(32'h7ff, 32'h80));
			2: begin
				cp = 21'($urandom_range(32'hffff, 32'h800));
				// move surrogates out of the way
				if (cp >= 21'h00d800 && cp <= 21'h00dfff)
					cp = cp ^ 21'h002000;
			end
			default: cp = 21'($urandom_range(32'h10ffff, 32'h10000));
		endcase
		return cp;
	endfunction

	function automatic void append_scalar(input logic [20:0] cp);
		if (cp < 21'h80) begin
			text_q.push_back(cp[7:0]);
		end else if (cp < 21'h800) begin
			text_q.push_back({3'b110, cp[10:6]});
			text_q.push_back({2'b10, cp[5:0]});
		end else if (cp < 21'h10000) begin
			text_q.push_back({4'b1110, cp[15:12]});
			text_q.push_back({2'b10, cp[11:6]});
			text_q.push_back({2'b10, cp[5:0]});
		end else begin
			text_q.push_back({5'b11110, cp[20:18]});
			text_q.push_back({2'b10, cp[17:12]});
			text_q.push_back({2'b10, cp[11:6]});
			text_q.push_back({2'b10, cp[5:0]});
		end
	endfunction

	// sequences that must be rejected: well-shaped ones rejected for their value, and invalid lead bytes
	function automatic void append_edge_form();
		case ($urandom_range(5))
			0: begin
				text_q.push_back(8'he0);
				text_q.push_back(rand_byte(8'h80, 8'h9f));
				text_q.push_back(rand_byte(8'h80, 8'hbf));
			end
			1: begin
				text_q.push_back(8'hed);
				text_q.push_back(rand_byte(8'ha0, 8'hbf));
				text_q.push_back(rand_byte(8'h80, 8'hbf));
			end
			2: begin
				text_q.push_back(8'hf0);
				text_q.push_back(rand_byte(8'h80, 8'h8f));
				text_q.push_back(rand_byte(8'h80, 8'hbf));
				text_q.push_back(rand_byte(8'h80, 8'hbf));
			end
			3: begin
				text_q.push_back(8'hf4);
				text_q.push_back(rand_byte(8'h90, 8'hbf));
				text_q.push_back(rand_byte(8'h80, 8'hbf));
				text_q.push_back(rand_byte(8'h80, 8'hbf));
			end
			4: begin
				text_q.push_back(rand_byte(8'hc0, 8'hc1));
				text_q.push_back(rand_byte(8'h80, 8'hbf));
			end
			default: text_q.push_back(rand_byte(8'hf5, 8'hff));
		endcase
	endfunction

	// mostly valid text, sometimes with a broken byte or a cut-off tail
	function automatic void build_text(input int scalars);
		int pick;
		text_q.delete();
		for (int i = 0; i < scalars; i++) begin
			if ($urandom_range(99) < 8)
				append_edge_form();
			else
				append_scalar(random_scalar());
		end
		pick = $urandom_range(99);
		if (pick < 12)
			text_q[$urandom_range(text_q.size() - 1)] = rand_byte(8'h00, 8'hff);
		else if (pick < 22 && text_q.size() > 1)
			void'(text_q.pop_back());
	endfunction

	task automatic test_valid_forms();
		text_q = '{8'h00, 8'hc2, 8'h80, 8'hdf, 8'hbf, 8'h7f};
		send_string();
		text_q = '{8'he0, 8'ha0, 8'h80, 8'hf4, 8'h8f, 8'hbf, 8'hbf};
		send_string();
	endtask

	task automatic test_range_faults();
		// surrogate ending the string
		text_q = '{8'hed, 8'ha0, 8'h80};
		send_string();
		// overlong three-byte form
		text_q = '{8'he0, 8'h9f, 8'hbf};
		send_string();
		// bad continuation wins over the pending overlong fault, rest is dropped
		text_q = '{8'hf0, 8'h8f, 8'h41, 8'h80};
		send_string();
	endtask

	task automatic test_bad_lead_and_truncation();
		// error on the last byte, the next string starts clean
		text_q = '{8'h80};
		send_string();
		text_q = '{8'he0};
		send_string();
	endtask

	task automatic test_random_text();
		build_text(60);
		send_string();
		while (sent_bytes < 450) begin
			build_text($urandom_range(1, 8));
			send_string();
		end
	endtask

	task automatic test_unstalled_burst();
		stall_en = 1'b0;
		while (sent_bytes < 600) begin
			build_text($urandom_range(1, 8));
			send_string();
		end
		stall_en = 1'b1;
	endtask

	task automatic test_random_noise();
		while (sent_bytes < 850) begin
			text_q.delete();
			repeat ($urandom_range(1, 12))
				text_q.push_back(rand_byte(8'h00, 8'hff));
			send_string();
		end
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	task automatic check_result();
		scalar_t want;
		if (pending_scalars.size() == 0) begin
			$display("%0t: unexpected item, code_point %0h status %0d start %0d done %b",
				$time, m_tdata[CODE_BITS-1:0], m_tuser,
				m_tdata[CODE_BITS+START_BITS-1:CODE_BITS], m_tlast);
			mismatch_count++;
		end else begin
			want = pending_scalars.pop_front();
			compare_field("code_point", 32'(want.code), 32'(m_tdata[CODE_BITS-1:0]));
			compare_field("status", 32'(want.status), 32'(m_tuser));
			compare_field("start_offset", want.start, m_tdata[CODE_BITS+START_BITS-1:CODE_BITS]);
			compare_field("string_done", 32'(want.done), 32'(m_tlast));
		end
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				check_result();
			m_tready <= stall_en ? ($urandom_range(99) >= 30) : 1'b1;
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_valid_forms();
		test_range_faults();
		test_bad_lead_and_truncation();
		test_random_text();
		test_unstalled_burst();
		test_random_noise();
		s_tvalid <= 1'b0;
		while (pending_scalars.size() != 0)
			@(posedge clk);
		// let any stray item show up
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
